### rtl/core/ufe_pkg.sv
package ufe_pkg;

  localparam int NODE_W = 14;
  localparam int SIZE_W = 15;
  localparam int CMD_W  = 2;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_CLEAR = 2'd0;
  localparam cmd_t CMD_FIND  = 2'd1;
  localparam cmd_t CMD_UNION = 2'd2;

endpackage

### rtl/core/union_find_engine_core.sv
// Channel   Direction  Fields                                  Handshake
// in_       request    cmd, node_a, node_b, set_size           in_valid / in_stall
// out_      result     root, joined                            out_valid / out_stall
//
// One request is worked on at a time; the parent table sits in a single memory
// with one write and one registered read port, and each walk step costs two reads.
// A find halves the path as it walks to the root; a union walks from node_a, then
// from node_b, and writes its link in the step that finds the second root; a
// clear sets entries 0 to min(set_size, NODES)-1 to their own index.
// After reset a pass sets every entry to its own index, with in_stall high.
// A stalled result waits in the output register while the next request is
// already taken.
module union_find_engine_core
  import ufe_pkg::*;
#(
  parameter int NODES = 16384
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  input  logic [SIZE_W-1:0] in_set_size,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] out_root,
  output logic              out_joined
);

  localparam int          AW      = $clog2(NODES);
  localparam int          CW      = AW + 1;
  localparam logic [31:0] NODES_U = 32'(NODES);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_WP,
    S_WGP,
    S_RESP
  } state_t;

  // Parent table.
  logic [AW-1:0] mem [NODES];
  logic [AW-1:0] rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_wd;
  logic [AW-1:0] mem_ra;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     lim_r, lim_nxt;
  logic [AW-1:0]     x_r, x_nxt;
  logic [AW-1:0]     ra_r, ra_nxt;
  logic [AW-1:0]     b_r, b_nxt;
  logic              b_in_r, b_in_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic              phase_r, phase_nxt;
  logic [NODE_W-1:0] res_root_r, res_root_nxt;
  logic              res_joined_r, res_joined_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] out_root_r, out_root_nxt;
  logic              out_joined_r, out_joined_nxt;

  logic          in_acc;
  logic          a_in;
  logic          b_in;
  logic [CW-1:0] clr_lim;
  logic [CW-1:0] cnt_inc;

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_root   = out_root_r;
  assign out_joined = out_joined_r;

  assign a_in    = (32'(in_node_a) < NODES_U);
  assign b_in    = (32'(in_node_b) < NODES_U);
  assign clr_lim = (32'(in_set_size) > NODES_U) ? CW'(NODES) : CW'(in_set_size);
  assign cnt_inc = cnt_r + CW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    // A read of the entry being written returns the new link.
    if (mem_we && (mem_wa == mem_ra)) begin
      rd_data_r <= mem_wd;
    end else begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    lim_nxt        = lim_r;
    x_nxt          = x_r;
    ra_nxt         = ra_r;
    b_nxt          = b_r;
    b_in_nxt       = b_in_r;
    cmd_nxt        = cmd_r;
    phase_nxt      = phase_r;
    res_root_nxt   = res_root_r;
    res_joined_nxt = res_joined_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_root_nxt   = out_root_r;
    out_joined_nxt = out_joined_r;
    mem_we         = 1'b0;
    mem_wa         = x_r;
    mem_wd         = rd_data_r;
    mem_ra         = x_r;

    case (state_r)
      S_INIT, S_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = cnt_r[AW-1:0];
        mem_wd  = cnt_r[AW-1:0];
        cnt_nxt = cnt_inc;
        if (cnt_inc == lim_r) begin
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_RESP;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt        = in_cmd;
          b_nxt          = AW'(in_node_b);
          b_in_nxt       = b_in;
          phase_nxt      = 1'b0;
          res_root_nxt   = '0;
          res_joined_nxt = 1'b0;
          cnt_nxt        = '0;
          lim_nxt        = clr_lim;
          case (in_cmd)
            CMD_CLEAR: begin
              state_nxt = (clr_lim == '0) ? S_RESP : S_CLEAR;
            end
            CMD_FIND, CMD_UNION: begin
              if (a_in) begin
                mem_ra    = AW'(in_node_a);
                x_nxt     = AW'(in_node_a);
                state_nxt = S_WP;
              end else begin
                res_root_nxt = in_node_a;
                state_nxt    = S_RESP;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_WP: begin
        if (rd_data_r != x_r) begin
          mem_ra    = rd_data_r;
          state_nxt = S_WGP;
        end else if (cmd_r == CMD_UNION && !phase_r) begin
          ra_nxt       = x_r;
          res_root_nxt = NODE_W'(x_r);
          if (b_in_r) begin
            mem_ra    = b_r;
            x_nxt     = b_r;
            phase_nxt = 1'b1;
          end else begin
            state_nxt = S_RESP;
          end
        end else if (cmd_r == CMD_UNION) begin
          // Both roots known: hang the second tree under the first.
          if (ra_r != x_r) begin
            mem_we         = 1'b1;
            mem_wa         = x_r;
            mem_wd         = ra_r;
            res_joined_nxt = 1'b1;
          end
          state_nxt = S_RESP;
        end else begin
          res_root_nxt = NODE_W'(x_r);
          state_nxt    = S_RESP;
        end
      end
      S_WGP: begin
        // Halve the path: link x to its grandparent and move there.
        mem_we    = 1'b1;
        mem_wa    = x_r;
        mem_wd    = rd_data_r;
        mem_ra    = rd_data_r;
        x_nxt     = rd_data_r;
        state_nxt = S_WP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_root_nxt   = res_root_r;
          out_joined_nxt = res_joined_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      lim_r       <= CW'(NODES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lim_r       <= lim_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r          <= x_nxt;
    ra_r         <= ra_nxt;
    b_r          <= b_nxt;
    b_in_r       <= b_in_nxt;
    cmd_r        <= cmd_nxt;
    phase_r      <= phase_nxt;
    res_root_r   <= res_root_nxt;
    res_joined_r <= res_joined_nxt;
    out_root_r   <= out_root_nxt;
    out_joined_r <= out_joined_nxt;
  end

endmodule

### rtl/core/ufe_checker.sv
module ufe_checker
  import ufe_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [NODE_W-1:0] out_root,
  input logic              out_joined
);

  // Requests taken whose results have not yet been delivered.
  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_root) && $stable(out_joined))
    else $error("stalled result changed");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request taken during table initialisation");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("second request taken while one is in progress");

  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != 2'd3) && (!out_valid || pend_r != 2'd0))
    else $error("result count does not match requests taken");

endmodule

bind union_find_engine_core ufe_checker u_ufe_checker (.*);
